// ----- design/dhfk_pkg.sv -----
// Shared types, constants and constant trig helper for the DH forward kinematics unit.
package dhfk_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int POS_BITS       = 18;

  localparam int TFRAC   = 8;                    // fraction bits of translations
  localparam int TW      = TRIG_FRAC_BITS + 2;   // trig value width
  localparam int RW      = TRIG_FRAC_BITS + 4;   // rotation entry width inside the chain
  localparam int LTW     = 26;                   // link translation width
  localparam int XLW     = 32;                   // accumulated translation width
  localparam int LEN_W   = 16;
  localparam int NUM_ANG = 7;                    // base tilt plus six joints
  localparam int NUM_LINKS = 9;
  localparam int SIN_LAT = 8;
  localparam int CELL_LAT = 3;

  localparam logic [30:0] HK9 = 31'd172272;
  localparam logic [30:0] HK [4] = '{31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713};

  typedef logic signed [TW-1:0]  trig_t;
  typedef logic signed [RW-1:0]  rot_t;
  typedef logic signed [LTW-1:0] lt_t;
  typedef logic signed [XLW-1:0] xl_t;
  typedef logic [LEN_W-1:0]      len_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sc_t;

  typedef sc_t [NUM_ANG-1:0] sc_set_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
    trig_t ca;
    trig_t sa;
    len_t  d;
    len_t  a;
  } link_t;

  typedef struct packed {
    rot_t [2:0][2:0] r;
    xl_t  [2:0]      t;
  } pose_t;

  typedef enum logic [2:0] {
    REG_SHOULDER_OFFSET = 3'd0,
    REG_UPPER_LINK      = 3'd1,
    REG_ARM_OFFSET      = 3'd2,
    REG_ELBOW_LINK      = 3'd3,
    REG_FOREARM_LINK    = 3'd4,
    REG_WRIST_OFFSET    = 3'd5,
    REG_TOOL_OFFSET     = 3'd6,
    REG_BASE_TILT       = 3'd7
  } reg_idx_e;

  localparam len_t RST_SHOULDER_OFFSET = 16'd18373;
  localparam len_t RST_UPPER_LINK      = 16'd5828;
  localparam len_t RST_ARM_OFFSET      = 16'd24440;
  localparam len_t RST_ELBOW_LINK      = 16'd1876;
  localparam len_t RST_FOREARM_LINK    = 16'd1853;
  localparam len_t RST_WRIST_OFFSET    = 16'd12303;
  localparam len_t RST_TOOL_OFFSET     = 16'd15000;
  localparam len_t RST_BASE_TILT       = 16'd11833;

  // Round half up and shift right arithmetically.
  function automatic logic signed [47:0] rnd_sh(input logic signed [47:0] v,
                                                input int unsigned sh);
    logic signed [47:0] half;
    half = 48'sd1 <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  // Sine of a constant angle, bit-exact with the sine pipeline.
  function automatic trig_t sin_const(input longint unsigned ang);
    longint unsigned a;
    longint unsigned quad;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    a    = ang & ((64'd1 << ANGLE_BITS) - 64'd1);
    quad = (a >> (ANGLE_BITS - 2)) & 64'd3;
    x    = (a & ((64'd1 << (ANGLE_BITS - 2)) - 64'd1)) << (32 - ANGLE_BITS);
    if (quad[0]) begin
      x = (64'd1 << 30) - x;
    end
    x2 = (x * x) >> 30;
    p  = 64'(HK9);
    for (int h = 0; h < 4; h++) begin
      p = 64'(HK[h]) - ((x2 * p) >> 30);
    end
    s = (x * p) >> 30;
    s = (s + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    if (s > (64'd1 << TRIG_FRAC_BITS)) begin
      s = 64'd1 << TRIG_FRAC_BITS;
    end
    return quad[1] ? -trig_t'(s) : trig_t'(s);
  endfunction

  localparam longint unsigned QT = 64'd1 << (ANGLE_BITS - 2);
  localparam trig_t TRIG_QT_S = sin_const(QT);
  localparam trig_t TRIG_QT_C = sin_const(2 * QT);
  localparam trig_t TRIG_MQ_S = sin_const(3 * QT);
  localparam trig_t TRIG_MQ_C = sin_const(4 * QT);
  localparam trig_t TRIG_Z_S  = sin_const(0);
  localparam trig_t TRIG_Z_C  = sin_const(QT);

endpackage

// ----- design/dhfk_sine.sv -----
// Pipelined fixed-point sine: quarter-wave reduction and odd Horner polynomial.
module dhfk_sine (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [dhfk_pkg::ANGLE_BITS-1:0]  ang_i,
  output dhfk_pkg::trig_t                  s_o
);
  import dhfk_pkg::*;

  localparam int XW = 31;
  localparam int SH = 30 - TRIG_FRAC_BITS;
  localparam logic [XW-1:0] ONE_Q30 = XW'(1) << 30;

  logic [1:0]    quad;
  logic [XW-1:0] x_in;
  logic [XW-1:0] xa_q [6];
  logic [1:0]    qa_q [6];
  logic [XW-1:0] x2_q [4];
  logic [XW-1:0] p_q  [4];
  logic [31:0]   s_q;
  logic [1:0]    qs_q;
  logic [61:0]   sq;
  logic [61:0]   fin;
  logic [61:0]   hprod [4];
  logic [XW-1:0] hin;
  logic [32:0]   rs;
  logic [32:0]   mag;
  trig_t         s_d;

  always_comb begin
    quad = ang_i[ANGLE_BITS-1 -: 2];
    x_in = XW'(ang_i[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    if (quad[0]) begin
      x_in = ONE_Q30 - x_in;
    end
  end

  always_comb begin
    sq  = 62'(xa_q[0]) * 62'(xa_q[0]);
    fin = 62'(xa_q[5]) * 62'(p_q[3]);
    hin = HK9;
    for (int h = 0; h < 4; h++) begin
      hin      = (h == 0) ? HK9 : p_q[(h == 0) ? 0 : h - 1];
      hprod[h] = 62'(x2_q[h]) * 62'(hin);
    end
  end

  always_comb begin
    rs  = (33'(s_q) + (33'(1) << (SH - 1))) >> SH;
    mag = (rs > (33'(1) << TRIG_FRAC_BITS)) ? (33'(1) << TRIG_FRAC_BITS) : rs;
    s_d = qs_q[1] ? -trig_t'(mag) : trig_t'(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q[0] <= x_in;
      qa_q[0] <= quad;
      xa_q[1] <= xa_q[0];
      qa_q[1] <= qa_q[0];
      x2_q[0] <= sq[60:30];
      for (int h = 0; h < 4; h++) begin
        xa_q[h+2] <= xa_q[h+1];
        qa_q[h+2] <= qa_q[h+1];
        p_q[h]    <= HK[h] - hprod[h][60:30];
      end
      for (int h = 0; h < 3; h++) begin
        x2_q[h+1] <= x2_q[h];
      end
      s_q  <= fin[61:30];
      qs_q <= qa_q[5];
      s_o  <= s_d;
    end
  end

endmodule

// ----- design/dhfk_cell.sv -----
// One link cell: builds the DH link transform and composes it onto the running pose.
module dhfk_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  dhfk_pkg::pose_t   pose_i,
  input  dhfk_pkg::link_t   link_i,
  input  dhfk_pkg::sc_set_t fwd_i,
  output logic              valid_o,
  output dhfk_pkg::pose_t   pose_o,
  output dhfk_pkg::sc_set_t fwd_o
);
  import dhfk_pkg::*;

  localparam int PRW = 2 * RW;
  localparam int PTW = RW + LTW;

  logic    va_q, vb_q, vc_q;
  sc_set_t fa_q, fb_q, fc_q;
  pose_t   pa_q;
  xl_t     ta_q [3];
  xl_t     tb_q [3];
  rot_t    br_d [3][3];
  rot_t    br_q [3][3];
  lt_t     bt_d [3];
  lt_t     bt_q [3];
  logic signed [PRW-1:0] pr_d [3][3][3];
  logic signed [PRW-1:0] pr_q [3][3][3];
  logic signed [PTW-1:0] pt_d [3][3];
  logic signed [PTW-1:0] pt_q [3][3];
  pose_t   pc_d, pc_q;

  // Link matrix from trig values and lengths.
  always_comb begin
    logic signed [31:0] cas, sas, cac, csa;
    logic signed [32:0] ac, as_;
    cas = link_i.ca * link_i.s;
    sas = link_i.sa * link_i.s;
    cac = link_i.ca * link_i.c;
    csa = link_i.c * link_i.sa;
    ac  = $signed({1'b0, link_i.a}) * link_i.c;
    as_ = $signed({1'b0, link_i.a}) * link_i.s;
    br_d[0][0] = rot_t'(link_i.c);
    br_d[0][1] = -rot_t'(rnd_sh(48'(cas), TRIG_FRAC_BITS));
    br_d[0][2] = rot_t'(rnd_sh(48'(sas), TRIG_FRAC_BITS));
    br_d[1][0] = rot_t'(link_i.s);
    br_d[1][1] = rot_t'(rnd_sh(48'(cac), TRIG_FRAC_BITS));
    br_d[1][2] = -rot_t'(rnd_sh(48'(csa), TRIG_FRAC_BITS));
    br_d[2][0] = '0;
    br_d[2][1] = rot_t'(link_i.sa);
    br_d[2][2] = rot_t'(link_i.ca);
    bt_d[0] = lt_t'(rnd_sh(48'(ac), TRIG_FRAC_BITS - TFRAC));
    bt_d[1] = lt_t'(rnd_sh(48'(as_), TRIG_FRAC_BITS - TFRAC));
    bt_d[2] = lt_t'({link_i.d, {TFRAC{1'b0}}});
  end

  // Products of the pose rotation with the link matrix.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          pr_d[i][j][k] = $signed(pa_q.r[i][k]) * $signed(br_q[k][j]);
        end
        pt_d[i][j] = $signed(pa_q.r[i][j]) * $signed(bt_q[j]);
      end
    end
  end

  // Sum, round and add the pose translation.
  always_comb begin
    logic signed [PRW+1:0] sr;
    logic signed [PTW+1:0] st;
    pc_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sr = (PRW+2)'(pr_q[i][j][0]) + (PRW+2)'(pr_q[i][j][1]) + (PRW+2)'(pr_q[i][j][2]);
        pc_d.r[i][j] = rot_t'(rnd_sh(48'(sr), TRIG_FRAC_BITS));
      end
      st = (PTW+2)'(pt_q[i][0]) + (PTW+2)'(pt_q[i][1]) + (PTW+2)'(pt_q[i][2]);
      pc_d.t[i] = xl_t'(rnd_sh(48'(st), TRIG_FRAC_BITS)) + tb_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pose_i;
      fa_q <= fwd_i;
      br_q <= br_d;
      bt_q <= bt_d;
      for (int i = 0; i < 3; i++) begin
        ta_q[i] <= pose_i.t[i];
        tb_q[i] <= ta_q[i];
      end
      pr_q <= pr_d;
      pt_q <= pt_d;
      fb_q <= fa_q;
      pc_q <= pc_d;
      fc_q <= fb_q;
    end
  end

  assign valid_o = vc_q;
  assign pose_o  = pc_q;
  assign fwd_o   = fc_q;

endmodule

// ----- design/dh_forward_kinematics_6dof_unit.sv -----
// Top level of the six-joint DH forward kinematics unit.
// Takes one set of six joint angles per clock and returns the end-effector pose
// (Q2.14 rotation, 0.01 mm position) through the sine pipelines, nine link cells
// that compose the transform chain from base to tool, and one output register.
// Sustained rate is one item per clock; a stall on the output holds the whole
// pipeline. Link lengths and the base tilt come from the configuration registers
// and must be written while idle; the block itself does not enforce this.
module dh_forward_kinematics_6dof_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         joint_one_angle_i,
  input  logic [15:0]         joint_two_angle_i,
  input  logic [15:0]         joint_three_angle_i,
  input  logic [15:0]         joint_four_angle_i,
  input  logic [15:0]         joint_five_angle_i,
  input  logic [15:0]         joint_six_angle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  rot_xx_o,
  output logic signed [15:0]  rot_xy_o,
  output logic signed [15:0]  rot_xz_o,
  output logic signed [15:0]  rot_yx_o,
  output logic signed [15:0]  rot_yy_o,
  output logic signed [15:0]  rot_yz_o,
  output logic signed [15:0]  rot_zx_o,
  output logic signed [15:0]  rot_zy_o,
  output logic signed [15:0]  rot_zz_o,
  output logic signed [dhfk_pkg::POS_BITS-1:0] pos_x_o,
  output logic signed [dhfk_pkg::POS_BITS-1:0] pos_y_o,
  output logic signed [dhfk_pkg::POS_BITS-1:0] pos_z_o
);
  import dhfk_pkg::*;

  localparam logic [ANGLE_BITS-1:0] QT_A = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic signed [XLW-1:0] POS_MAX = XLW'((64'd1 << (POS_BITS - 1)) - 64'd1);
  localparam logic signed [XLW-1:0] POS_MIN = -POS_MAX - XLW'(1);
  localparam logic signed [RW-1:0]  ROT_MAX = RW'(16384);

  len_t shoulder_q, upper_q, arm_q, elbow_q, forearm_q, wrist_q, tool_q, tilt_q;

  logic en;
  logic out_valid_q;
  logic [SIN_LAT-1:0] tv_q;

  logic [ANGLE_BITS-1:0] ang [NUM_ANG];
  sc_set_t trig_set;

  pose_t   pose_w [NUM_LINKS+1];
  logic    cv     [NUM_LINKS+1];
  sc_set_t cf     [NUM_LINKS+1];
  link_t   link   [NUM_LINKS];

  rot_t rot_d [3][3];
  logic signed [POS_BITS-1:0] pos_d [3];
  logic signed [15:0] rot_q [3][3];
  logic signed [POS_BITS-1:0] pos_q [3];

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shoulder_q <= RST_SHOULDER_OFFSET;
      upper_q    <= RST_UPPER_LINK;
      arm_q      <= RST_ARM_OFFSET;
      elbow_q    <= RST_ELBOW_LINK;
      forearm_q  <= RST_FOREARM_LINK;
      wrist_q    <= RST_WRIST_OFFSET;
      tool_q     <= RST_TOOL_OFFSET;
      tilt_q     <= RST_BASE_TILT;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SHOULDER_OFFSET: shoulder_q <= cfg_data_i;
        REG_UPPER_LINK:      upper_q    <= cfg_data_i;
        REG_ARM_OFFSET:      arm_q      <= cfg_data_i;
        REG_ELBOW_LINK:      elbow_q    <= cfg_data_i;
        REG_FOREARM_LINK:    forearm_q  <= cfg_data_i;
        REG_WRIST_OFFSET:    wrist_q    <= cfg_data_i;
        REG_TOOL_OFFSET:     tool_q     <= cfg_data_i;
        REG_BASE_TILT:       tilt_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Angles for the sine pipelines: negated base tilt, then the six joints.
  always_comb begin
    ang[0] = '0 - tilt_q[ANGLE_BITS-1:0];
    ang[1] = joint_one_angle_i[ANGLE_BITS-1:0];
    ang[2] = joint_two_angle_i[ANGLE_BITS-1:0];
    ang[3] = joint_three_angle_i[ANGLE_BITS-1:0];
    ang[4] = joint_four_angle_i[ANGLE_BITS-1:0];
    ang[5] = joint_five_angle_i[ANGLE_BITS-1:0];
    ang[6] = joint_six_angle_i[ANGLE_BITS-1:0];
  end

  for (genvar g = 0; g < NUM_ANG; g++) begin : g_trig
    dhfk_sine u_sin (
      .clk_i (clk_i),
      .en_i  (en),
      .ang_i (ang[g]),
      .s_o   (trig_set[g].s)
    );
    dhfk_sine u_cos (
      .clk_i (clk_i),
      .en_i  (en),
      .ang_i (ang[g] + QT_A),
      .s_o   (trig_set[g].c)
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else if (en) begin
      tv_q <= {tv_q[SIN_LAT-2:0], in_valid_i};
    end
  end

  // Start from the identity pose.
  always_comb begin
    pose_w[0] = '0;
    for (int i = 0; i < 3; i++) begin
      pose_w[0].r[i][i] = RW'(1) << TRIG_FRAC_BITS;
    end
  end

  assign cv[0] = tv_q[SIN_LAT-1];
  assign cf[0] = trig_set;

  // Link parameters for each cell, from the trig set travelling with the item, fixed angles and the length registers.
  always_comb begin
    link[0] = '{c: TRIG_QT_C, s: TRIG_QT_S, ca: cf[0][0].c, sa: cf[0][0].s,
                d: '0, a: '0};
    link[1] = '{c: TRIG_MQ_C, s: TRIG_MQ_S, ca: TRIG_Z_C, sa: TRIG_Z_S, d: '0, a: '0};
    link[2] = '{c: cf[2][1].c, s: cf[2][1].s, ca: TRIG_MQ_C, sa: TRIG_MQ_S,
                d: shoulder_q, a: '0};
    link[3] = '{c: cf[3][2].c, s: cf[3][2].s, ca: TRIG_QT_C, sa: TRIG_QT_S,
                d: '0, a: upper_q};
    link[4] = '{c: cf[4][3].c, s: cf[4][3].s, ca: TRIG_MQ_C, sa: TRIG_MQ_S,
                d: arm_q, a: elbow_q};
    link[5] = '{c: cf[5][4].c, s: cf[5][4].s, ca: TRIG_QT_C, sa: TRIG_QT_S,
                d: '0, a: forearm_q};
    link[6] = '{c: cf[6][5].c, s: cf[6][5].s, ca: TRIG_MQ_C, sa: TRIG_MQ_S,
                d: wrist_q, a: '0};
    link[7] = '{c: cf[7][6].c, s: cf[7][6].s, ca: TRIG_QT_C, sa: TRIG_QT_S,
                d: '0, a: '0};
    link[8] = '{c: TRIG_Z_C, s: TRIG_Z_S, ca: TRIG_Z_C, sa: TRIG_Z_S, d: tool_q, a: '0};
  end

  for (genvar k = 0; k < NUM_LINKS; k++) begin : g_cell
    dhfk_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[k]),
      .pose_i  (pose_w[k]),
      .link_i  (link[k]),
      .fwd_i   (cf[k]),
      .valid_o (cv[k+1]),
      .pose_o  (pose_w[k+1]),
      .fwd_o   (cf[k+1])
    );
  end

  // Clamp rotation, round and saturate position.
  always_comb begin
    logic signed [47:0] p;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_d[i][j] = $signed(pose_w[NUM_LINKS].r[i][j]);
        if (rot_d[i][j] > ROT_MAX) begin
          rot_d[i][j] = ROT_MAX;
        end
        if (rot_d[i][j] < -ROT_MAX) begin
          rot_d[i][j] = -ROT_MAX;
        end
      end
      p = rnd_sh(48'($signed(pose_w[NUM_LINKS].t[i])), TFRAC);
      if (p > 48'(POS_MAX)) begin
        pos_d[i] = POS_BITS'(POS_MAX);
      end else if (p < 48'(POS_MIN)) begin
        pos_d[i] = POS_BITS'(POS_MIN);
      end else begin
        pos_d[i] = POS_BITS'(p);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cv[NUM_LINKS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && cv[NUM_LINKS]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rot_q[i][j] <= 16'(rot_d[i][j]);
        end
        pos_q[i] <= pos_d[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign rot_xx_o = rot_q[0][0];
  assign rot_xy_o = rot_q[0][1];
  assign rot_xz_o = rot_q[0][2];
  assign rot_yx_o = rot_q[1][0];
  assign rot_yy_o = rot_q[1][1];
  assign rot_yz_o = rot_q[1][2];
  assign rot_zx_o = rot_q[2][0];
  assign rot_zy_o = rot_q[2][1];
  assign rot_zz_o = rot_q[2][2];
  assign pos_x_o  = pos_q[0];
  assign pos_y_o  = pos_q[1];
  assign pos_z_o  = pos_q[2];

endmodule

// ----- design/dhfk_checker.sv -----
// Port-level checks for the DH forward kinematics unit, bound to the top level.
module dhfk_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic signed [15:0]  rot_xx_o,
  input logic signed [15:0]  rot_yy_o,
  input logic signed [15:0]  rot_zz_o,
  input logic signed [dhfk_pkg::POS_BITS-1:0] pos_x_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(rot_xx_o))
    else $error("result item dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register is empty");

  a_ready_when_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input stalled while result is being taken");

  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rot_xx_o <= 16'sd16384 && rot_xx_o >= -16'sd16384 &&
                    rot_yy_o <= 16'sd16384 && rot_yy_o >= -16'sd16384 &&
                    rot_zz_o <= 16'sd16384 && rot_zz_o >= -16'sd16384)
    else $error("rotation entry outside unit range");

endmodule

bind dh_forward_kinematics_6dof_unit dhfk_checker u_dhfk_checker (.*);
